>>> src/nprl_pkg.sv
// Package for the neighbor probe rate limiter.
// Holds cache sizes, entry layouts, the scan state type and register codes.
// No dependencies.
package nprl_pkg;

    localparam int V4_ENTRIES = 16;
    localparam int V6_ENTRIES = 16;
    localparam int V4_AW = (V4_ENTRIES > 1) ? $clog2(V4_ENTRIES) : 1;
    localparam int V6_AW = (V6_ENTRIES > 1) ? $clog2(V6_ENTRIES) : 1;
    localparam int IDX_W = (V4_AW > V6_AW) ? V4_AW : V6_AW;
    localparam logic [IDX_W-1:0] V4_LAST = IDX_W'(V4_ENTRIES - 1);
    localparam logic [IDX_W-1:0] V6_LAST = IDX_W'(V6_ENTRIES - 1);

    localparam logic [31:0] COOL_RESET = 32'd1000;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_V4_COOL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_V6_COOL = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] port;
        logic [63:0] stamp;
    } t_v4_word;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [31:0] port;
        logic [63:0] stamp;
    } t_v6_word;

    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [31:0] port;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic cooling;
    } t_verdict;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE
    } t_state;

endpackage

>>> src/nprl_ram.sv
// Generic single-write, single-read memory with registered read data.
// Used for the per-family neighbor caches. No dependencies.
module nprl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/nprl_cmp.sv
// Shared compare unit: matches one cache entry against the request key and
// checks the cooldown window with a 64-bit modular difference. Uses nprl_pkg.
module nprl_cmp
    import nprl_pkg::*;
(
    input  t_entry      i_entry,
    input  t_entry      i_key,
    input  logic [31:0] i_cooldown,
    output t_verdict    o_verdict
);

    logic [63:0] elapsed;

    assign elapsed = i_key.stamp - i_entry.stamp;

    always_comb begin
        o_verdict.hit = (i_entry.addr_hi == i_key.addr_hi)
                      && (i_entry.addr_lo == i_key.addr_lo)
                      && (i_entry.port == i_key.port);
        o_verdict.cooling = (elapsed < {32'd0, i_cooldown});
    end

endmodule

>>> src/neighbor_probe_rate_limiter.sv
// Top level of the neighbor probe rate limiter: request latch, scan
// sequencer, cooldown registers and per-family caches. Uses nprl_pkg,
// nprl_ram and nprl_cmp.
//
// A request beat is taken when start is high and busy is low. The block
// scans the selected family's cache one entry per cycle through a single
// registered read port. A hit that is still cooling raises o_done from the
// scan state through the registered done flag; an allowed hit or a miss
// first passes the write state. busy falls in the cycle o_done is high,
// and a new request may be started in that same cycle.
// The result is shown for one cycle only and the receiver cannot stall it.
// Cooldown registers may be written only while busy is low.
module neighbor_probe_rate_limiter
    import nprl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_family_v6,
    input  logic [63:0]          i_addr_high,
    input  logic [63:0]          i_addr_low,
    input  logic [31:0]          i_if_index,
    input  logic [63:0]          i_now_ms,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    output logic                 o_done,
    output logic                 o_allowed
);

    t_state r_state;
    t_state n_state;

    logic             r_fam;
    t_entry           r_key;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_slot;
    logic [V4_AW-1:0] r_v4_ptr;
    logic [V6_AW-1:0] r_v6_ptr;
    logic [V4_ENTRIES-1:0] r_v4_vld;
    logic [V6_ENTRIES-1:0] r_v6_vld;
    logic [31:0]      r_v4_cool;
    logic [31:0]      r_v6_cool;
    logic             r_done;
    logic             r_allowed;
    logic             n_done;
    logic             n_allowed;

    logic [IDX_W-1:0] last_idx;
    logic             at_last;
    logic [IDX_W-1:0] rd_idx;
    logic             v4_we;
    logic             v6_we;
    t_v4_word         v4_rd;
    t_v6_word         v6_rd;
    t_v4_word         v4_wr;
    t_v6_word         v6_wr;
    t_entry           v4_ent;
    t_entry           v6_ent;
    t_entry           cur_ent;
    logic [31:0]      cur_cool;
    t_verdict         verdict;
    logic             accept;

    assign accept = start && (r_state == S_IDLE);

    nprl_ram #(
        .WIDTH($bits(t_v4_word)),
        .DEPTH(V4_ENTRIES),
        .AW   (V4_AW)
    ) u_v4_ram (
        .i_clk  (i_clk),
        .i_we   (v4_we),
        .i_waddr(r_slot[V4_AW-1:0]),
        .i_wdata(v4_wr),
        .i_raddr(rd_idx[V4_AW-1:0]),
        .o_rdata(v4_rd)
    );

    nprl_ram #(
        .WIDTH($bits(t_v6_word)),
        .DEPTH(V6_ENTRIES),
        .AW   (V6_AW)
    ) u_v6_ram (
        .i_clk  (i_clk),
        .i_we   (v6_we),
        .i_waddr(r_slot[V6_AW-1:0]),
        .i_wdata(v6_wr),
        .i_raddr(rd_idx[V6_AW-1:0]),
        .o_rdata(v6_rd)
    );

    always_comb begin
        v4_ent = '0;
        if (r_v4_vld[r_idx[V4_AW-1:0]]) begin
            v4_ent.addr_lo = {32'd0, v4_rd.addr};
            v4_ent.port    = v4_rd.port;
            v4_ent.stamp   = v4_rd.stamp;
        end
        v6_ent = '0;
        if (r_v6_vld[r_idx[V6_AW-1:0]]) begin
            v6_ent.addr_hi = v6_rd.addr_hi;
            v6_ent.addr_lo = v6_rd.addr_lo;
            v6_ent.port    = v6_rd.port;
            v6_ent.stamp   = v6_rd.stamp;
        end
        cur_ent  = r_fam ? v6_ent : v4_ent;
        cur_cool = r_fam ? r_v6_cool : r_v4_cool;
        last_idx = r_fam ? V6_LAST : V4_LAST;
        at_last  = (r_idx == last_idx);
    end

    assign v4_wr = '{addr: r_key.addr_lo[31:0], port: r_key.port, stamp: r_key.stamp};
    assign v6_wr = '{addr_hi: r_key.addr_hi, addr_lo: r_key.addr_lo,
                     port: r_key.port, stamp: r_key.stamp};

    nprl_cmp u_cmp (
        .i_entry   (cur_ent),
        .i_key     (r_key),
        .i_cooldown(cur_cool),
        .o_verdict (verdict)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (verdict.hit) begin
                    n_state = verdict.cooling ? S_IDLE : S_WRITE;
                end else if (at_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_idx    = '0;
        v4_we     = 1'b0;
        v6_we     = 1'b0;
        n_done    = 1'b0;
        n_allowed = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_idx = '0;
            end
            S_SCAN: begin
                rd_idx = at_last ? '0 : r_idx + 1'b1;
                if (verdict.hit && verdict.cooling) begin
                    n_done = 1'b1;
                end
            end
            S_WRITE: begin
                v4_we     = !r_fam;
                v6_we     = r_fam;
                n_done    = 1'b1;
                n_allowed = 1'b1;
            end
            default: begin
                rd_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_slot    <= '0;
            r_v4_ptr  <= '0;
            r_v6_ptr  <= '0;
            r_v4_vld  <= '0;
            r_v6_vld  <= '0;
            r_v4_cool <= COOL_RESET;
            r_v6_cool <= COOL_RESET;
            r_done    <= 1'b0;
            r_allowed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_allowed <= n_allowed;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_V4_COOL: r_v4_cool <= i_cfg_wdata;
                    CFG_V6_COOL: r_v6_cool <= i_cfg_wdata;
                    default:     r_v4_cool <= r_v4_cool;
                endcase
            end

            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if (r_state == S_SCAN && !verdict.hit) begin
                if (at_last) begin
                    if (r_fam) begin
                        r_slot   <= IDX_W'(r_v6_ptr);
                        r_v6_ptr <= (r_v6_ptr == V6_LAST[V6_AW-1:0]) ? '0
                                                                    : r_v6_ptr + 1'b1;
                    end else begin
                        r_slot   <= IDX_W'(r_v4_ptr);
                        r_v4_ptr <= (r_v4_ptr == V4_LAST[V4_AW-1:0]) ? '0
                                                                    : r_v4_ptr + 1'b1;
                    end
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (r_state == S_SCAN) begin
                r_slot <= r_idx;
            end

            if (v4_we) begin
                r_v4_vld[r_slot[V4_AW-1:0]] <= 1'b1;
            end
            if (v6_we) begin
                r_v6_vld[r_slot[V6_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fam         <= i_family_v6;
            r_key.addr_hi <= i_family_v6 ? i_addr_high : 64'd0;
            r_key.addr_lo <= i_family_v6 ? i_addr_low : {32'd0, i_addr_low[31:0]};
            r_key.port    <= i_if_index;
            r_key.stamp   <= i_now_ms;
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_allowed = r_allowed;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while a scan is still running");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not start a scan");

    a_refuse_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_allowed) |-> ($past(r_state) == S_SCAN))
        else $error("refusal not decided by the scan");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({v4_we, v6_we}))
        else $error("both caches written in one cycle");

    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v4_we || v6_we) |=> (o_done && o_allowed))
        else $error("cache write without an allowed result");
`endif

endmodule

>>> tb/neighbor_probe_rate_limiter_test.sv
`timescale 1ns / 100ps
// Testbench for neighbor_probe_rate_limiter: directed and random probe requests checked
// against an in-bench model of both neighbor caches and their cooldown registers.
// Depends on nprl_pkg and the neighbor_probe_rate_limiter RTL.
module neighbor_probe_rate_limiter_test;
    import nprl_pkg::*;

    localparam int POOL_KEYS = 20;
    localparam int RANDOM_PER_PHASE = 584;

    typedef struct {
        logic        family_v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [31:0] if_index;
        logic [63:0] now_ms;
    } t_probe_req;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] port;
    } t_neighbor_key;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_family_v6;
    logic [63:0]          i_addr_high;
    logic [63:0]          i_addr_low;
    logic [31:0]          i_if_index;
    logic [63:0]          i_now_ms;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]          i_cfg_wdata;
    logic                 o_done;
    logic                 o_allowed;

    t_v4_word      v4_cache [V4_ENTRIES];
    t_v6_word      v6_cache [V6_ENTRIES];
    int            v4_ptr;
    int            v6_ptr;
    logic [31:0]   v4_cool_ms;
    logic [31:0]   v6_cool_ms;
    bit            pending_verdicts [$];
    bit            verdict_due;
    int            fail_count;
    int            beats_checked;
    int            beats_allowed;
    t_neighbor_key key_pool [2][POOL_KEYS];
    logic [63:0]   clock_ms;
    int            send_idle_pct;

    neighbor_probe_rate_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_family_v6 (i_family_v6),
        .i_addr_high (i_addr_high),
        .i_addr_low  (i_addr_low),
        .i_if_index  (i_if_index),
        .i_now_ms    (i_now_ms),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_allowed   (o_allowed)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit predict_verdict(input t_probe_req r);
        bit          hit;
        int          slot;
        logic [63:0] age;
        hit = 1'b0;
        slot = 0;
        if (!r.family_v6) begin
            for (int k = 0; k < V4_ENTRIES; k++) begin
                if (!hit && v4_cache[k].addr == r.addr_low[31:0] &&
                    v4_cache[k].port == r.if_index) begin
                    hit = 1'b1;
                    slot = k;
                end
            end
            if (hit) begin
                age = r.now_ms - v4_cache[slot].stamp;
                if (age < {32'd0, v4_cool_ms})
                    return 1'b0;
                v4_cache[slot].stamp = r.now_ms;
                return 1'b1;
            end
            v4_cache[v4_ptr] = '{addr: r.addr_low[31:0], port: r.if_index, stamp: r.now_ms};
            v4_ptr = (v4_ptr == V4_ENTRIES - 1) ? 0 : v4_ptr + 1;
            return 1'b1;
        end
        for (int k = 0; k < V6_ENTRIES; k++) begin
            if (!hit && v6_cache[k].addr_hi == r.addr_high &&
                v6_cache[k].addr_lo == r.addr_low && v6_cache[k].port == r.if_index) begin
                hit = 1'b1;
                slot = k;
            end
        end
        if (hit) begin
            age = r.now_ms - v6_cache[slot].stamp;
            if (age < {32'd0, v6_cool_ms})
                return 1'b0;
            v6_cache[slot].stamp = r.now_ms;
            return 1'b1;
        end
        v6_cache[v6_ptr] = '{addr_hi: r.addr_high, addr_lo: r.addr_low,
                             port: r.if_index, stamp: r.now_ms};
        v6_ptr = (v6_ptr == V6_ENTRIES - 1) ? 0 : v6_ptr + 1;
        return 1'b1;
    endfunction

    // The request stays on the ports until a beat is taken; in this task start
    // is lowered only when an idle cycle is inserted.
    task automatic send_probe(input t_probe_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start       <= 1'b1;
        i_family_v6 <= r.family_v6;
        i_addr_high <= r.addr_high;
        i_addr_low  <= r.addr_low;
        i_if_index  <= r.if_index;
        i_now_ms    <= r.now_ms;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_verdicts.push_back(predict_verdict(r));
    endtask

    task automatic probe(input bit fam, input logic [63:0] hi, input logic [63:0] lo,
                         input logic [31:0] port, input logic [63:0] now);
        t_probe_req r;
        r = '{family_v6: fam, addr_high: hi, addr_low: lo, if_index: port, now_ms: now};
        send_probe(r);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cooldown(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] ms);
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (busy);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= ms;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_V4_COOL)
            v4_cool_ms = ms;
        else
            v6_cool_ms = ms;
    endtask

    task automatic refresh_key_pool();
        for (int f = 0; f < 2; f++) begin
            key_pool[f][0] = '{hi: 64'd0, lo: 64'd0, port: 32'd0};
            for (int k = 1; k < POOL_KEYS; k++)
                key_pool[f][k] = '{hi: rand64(), lo: rand64(), port: $urandom};
        end
    endtask

    // Mostly revisits a small set of neighbors with time moving forward, so
    // hits, refusals and evictions all occur; the rest is unrelated noise.
    function automatic t_probe_req random_request();
        t_probe_req    r;
        t_neighbor_key key;
        int            roll;
        r.family_v6 = $urandom_range(1);
        if ($urandom_range(99) < 88)
            key = key_pool[r.family_v6][$urandom_range(POOL_KEYS - 1)];
        else
            key = '{hi: rand64(), lo: rand64(), port: $urandom};
        roll = $urandom_range(99);
        if (roll < 4)
            clock_ms = clock_ms - {32'd0, $urandom};
        else if (roll < 6)
            clock_ms = rand64();
        else
            clock_ms = clock_ms + $urandom_range(120);
        r.if_index = key.port;
        r.now_ms = clock_ms;
        if (r.family_v6) begin
            r.addr_high = key.hi;
            r.addr_low = key.lo;
        end else begin
            r.addr_high = rand64();
            r.addr_low = {$urandom, key.lo[31:0]};
        end
        return r;
    endfunction

    task automatic run_random_phase(input int idle_pct, input logic [63:0] start_ms,
                                    input logic [31:0] v4_ms, input logic [31:0] v6_ms);
        write_cooldown(CFG_V4_COOL, v4_ms);
        write_cooldown(CFG_V6_COOL, v6_ms);
        refresh_key_pool();
        clock_ms = start_ms;
        send_idle_pct = idle_pct;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2)
                wait_drained();
            send_probe(random_request());
        end
        wait_drained();
    endtask

    // Untouched entries hold address 0, interface 0 and stamp 0.
    task automatic test_cleared_entries();
        send_idle_pct = 0;
        probe(1'b0, 64'd0, 64'd0, 32'd0, 64'd0);
        probe(1'b1, 64'd0, 64'd0, 32'd0, 64'd999);
        probe(1'b0, 64'd0, 64'd0, 32'd0, 64'd1000);
        probe(1'b0, '1, 64'hFFFF_FFFF_0000_0000, 32'd0, 64'd1999);
        wait_drained();
    endtask

    task automatic test_field_extremes();
        send_idle_pct = 0;
        probe(1'b0, '1, '1, '1, '1);
        probe(1'b0, 64'd0, 64'h0000_0000_FFFF_FFFF, '1, 64'd998);
        probe(1'b0, '1, 64'h1234_5678_FFFF_FFFF, '1, 64'd999);
        probe(1'b1, '1, '1, '1, 64'h8000_0000_0000_0000);
        probe(1'b1, '1, '1, '1, 64'd5);
        probe(1'b1, '1, 64'd0, '1, 64'd6);
        probe(1'b1, 64'd0, '1, 32'd0, 64'd7);
        probe(1'b1, '1, '1, 32'd0, 64'd8);
        wait_drained();
    endtask

    task automatic test_cooldown_extremes();
        send_idle_pct = 0;
        write_cooldown(CFG_V4_COOL, 32'd0);
        write_cooldown(CFG_V6_COOL, 32'd0);
        probe(1'b0, 64'd0, 64'd0, 32'd0, 64'd1000);
        probe(1'b1, '1, '1, '1, 64'd5);
        wait_drained();
        write_cooldown(CFG_V4_COOL, '1);
        write_cooldown(CFG_V6_COOL, '1);
        probe(1'b0, 64'd0, 64'd0, 32'd0, 64'd1000 + 64'hFFFF_FFFE);
        probe(1'b0, 64'd0, 64'd0, 32'd0, 64'd1000 + 64'hFFFF_FFFF);
        probe(1'b1, '1, '1, '1, 64'd5 + 64'hFFFF_FFFE);
        probe(1'b1, '1, '1, '1, 64'd5 + 64'hFFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, rand64(), $urandom_range(3000, 500), $urandom_range(3000, 500));
        run_random_phase(69, rand64(), $urandom_range(3000, 500), $urandom_range(3000, 500));
        run_random_phase(38, 64'hFFFF_FFFF_FFFF_FFFF - 64'd60000,
                         $urandom_range(3000, 500), $urandom_range(3000, 500));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_verdicts.size() == 0) begin
                $error("allowed: no result expected, got %0d", o_allowed);
                fail_count++;
            end else begin
                verdict_due = pending_verdicts.pop_front();
                beats_checked++;
                if (verdict_due)
                    beats_allowed++;
                if (o_allowed !== verdict_due) begin
                    $error("allowed: expected %0d, got %0d", verdict_due, o_allowed);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("neighbor_probe_rate_limiter_test: errors");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_family_v6 <= 1'b0;
        i_addr_high <= '0;
        i_addr_low  <= '0;
        i_if_index  <= '0;
        i_now_ms    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_V4_COOL;
        i_cfg_wdata <= '0;
        fail_count = 0;
        beats_checked = 0;
        beats_allowed = 0;
        send_idle_pct = 0;
        v4_cool_ms = COOL_RESET;
        v6_cool_ms = COOL_RESET;
        v4_ptr = 0;
        v6_ptr = 0;
        for (int k = 0; k < V4_ENTRIES; k++)
            v4_cache[k] = '0;
        for (int k = 0; k < V6_ENTRIES; k++)
            v6_cache[k] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_entries();
        test_field_extremes();
        test_cooldown_extremes();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Checked %0d probe verdicts (%0d allowed, %0d refused).",
                 beats_checked, beats_allowed, beats_checked - beats_allowed);
        $display("Covered cleared entries, field extremes, zero and maximum cooldowns, %s",
                 "and random traffic in three idle mixes.");
        if (fail_count == 0 && pending_verdicts.size() == 0) begin
            $display("neighbor_probe_rate_limiter_test: clean");
        end else begin
            $display("neighbor_probe_rate_limiter_test: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/nprl_pkg.sv
src/nprl_ram.sv
src/nprl_cmp.sv
src/neighbor_probe_rate_limiter.sv
tb/neighbor_probe_rate_limiter_test.sv
